// ----- src/ir_range_linearizer_ema_top_assert.svh -----
// assertion macros shared by the range linearizer modules
`ifndef IR_RANGE_LINEARIZER_EMA_TOP_ASSERT_SVH
`define IR_RANGE_LINEARIZER_EMA_TOP_ASSERT_SVH

// same-cycle implication
`define IRLE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("irle: same-cycle check failed");

// next-cycle implication
`define IRLE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("irle: next-cycle check failed");

// invariant
`define IRLE_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("irle: invariant failed");

`endif

// ----- src/irle_pkg.sv -----
// constants, tables and types of the ir range linearizer
package irle_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int ADC_BITS    = 10;
    localparam int FRAC_BITS   = 16;
    localparam int PRIME_COUNT = 10;
    localparam int PRIME_W     = $clog2(PRIME_COUNT + 1);

    localparam int DIST_W      = 20;
    localparam int GAIN_W      = 17;
    localparam int GAIN_FRAC   = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32768);
    localparam int MIX_W       = DIST_W + GAIN_W;

    // volts = sample * 5 * 2^FRAC_BITS / ADC_MAX, split into integer and remainder factors
    localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
    localparam int SCALE_INT   = (5 << FRAC_BITS) / ADC_MAX;
    localparam int SCALE_REM   = (5 << FRAC_BITS) % ADC_MAX;
    localparam int V_W         = 19;

    localparam int TH_N        = 10;
    localparam int SEG_N       = 9;
    localparam int SEG_W       = $clog2(SEG_N);

    localparam logic [V_W-1:0] THRESH [TH_N] = '{
        19'd25187, 19'd28194, 19'd32329, 19'd38720, 19'd47366,
        19'd58644, 19'd84207, 19'd106386, 19'd150369, 19'd205254
    };

    // segment slopes are all negative: magnitudes in micro-cm per volt
    localparam int ICPT_W      = 28;
    localparam logic [ICPT_W-1:0] SLOPE_MAG [SEG_N] = '{
        28'd217916667, 28'd158484848, 28'd102549020, 28'd75797101, 28'd58111111,
        28'd25637255, 28'd14774011, 28'd7450142, 28'd5970320
    };
    localparam logic [ICPT_W-1:0] ICPT [SEG_N] = '{
        28'd163750000, 28'd138181818, 28'd110588235, 28'd94782609, 28'd82000000,
        28'd52941176, 28'd38983051, 28'd27094017, 28'd23698630
    };

    localparam longint unsigned FAR_Q_FULL = ((longint'(999) << FRAC_BITS) + 50) / 100;
    localparam logic [DIST_W-1:0] FAR_Q    = DIST_W'(FAR_Q_FULL);

    // shared multiplier operands
    localparam int MUL_A_W     = 28;
    localparam int MUL_B_W     = DIST_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // divide by prime count through a reciprocal
    localparam int PRIME_SHIFT = 26;
    localparam int PRIME_RECIP = ((1 << PRIME_SHIFT) + PRIME_COUNT - 1) / PRIME_COUNT;

    // segment value over 1e8 gives metres in the distance format
    localparam int ACC_W       = ICPT_W + FRAC_BITS;
    localparam int DIVISOR     = 100000000;
    // estimate from the dividend bits above DIV_HI_LSB, never high and at most one low
    localparam int DIV_HI_LSB      = 26;
    localparam int DIV_RECIP_SHIFT = 28;
    localparam logic [MUL_A_W-1:0] DIV_RECIP =
        MUL_A_W'((64'd1 << (DIV_HI_LSB + DIV_RECIP_SHIFT)) / DIVISOR);

    typedef enum logic [1:0] {
        RS_IN_RANGE = 2'd0,
        RS_TOO_FAR  = 2'd1,
        RS_TOO_NEAR = 2'd2
    } t_range_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SEG,
        S_MUL,
        S_SUB,
        S_DIV,
        S_MIX,
        S_PRIME,
        S_AVG,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_EST,
        DS_BACK,
        DS_FIX
    } t_div_state;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- src/irle_if.sv -----
// valid/ready channel interfaces of the ir range linearizer
interface irle_sample_if;
    logic                          valid;
    logic                          ready;
    logic [irle_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface irle_result_if;
    logic                        valid;
    logic                        ready;
    logic [irle_pkg::DIST_W-1:0] raw_distance;
    logic [irle_pkg::DIST_W-1:0] filtered_distance;
    logic [1:0]                  range_status;

    modport source (output valid, output raw_distance, output filtered_distance,
                    output range_status, input ready);
    modport sink   (input valid, input raw_distance, input filtered_distance,
                    input range_status, output ready);
endinterface

interface irle_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [irle_pkg::GAIN_W-1:0] smoothing_gain;

    modport source (output valid, output smoothing_gain, input ready);
    modport sink   (input valid, input smoothing_gain, output ready);
endinterface

// ----- src/irle_div.sv -----
// divider by the constant 1e8 on the shared multiplier: estimate, back-multiply, one fix step
`include "ir_range_linearizer_ema_top_assert.svh"

module irle_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  irle_pkg::t_div_req            i_req,
    input  logic [irle_pkg::PROD_W-1:0]   i_mul_p,
    output logic [irle_pkg::MUL_A_W-1:0]  o_mul_a,
    output logic [irle_pkg::MUL_B_W-1:0]  o_mul_b,
    output irle_pkg::t_div_rsp            o_rsp
);
    import irle_pkg::*;

    t_div_state        r_dstate;
    t_div_state        n_dstate;
    logic              r_done;
    logic [ACC_W-1:0]  r_num;
    logic [DIST_W-1:0] r_quo;
    logic [PROD_W-1:0] r_back;

    logic [ACC_W-1:0]  rem;
    logic              rem_ge;

    assign rem    = r_num - r_back[ACC_W-1:0];
    assign rem_ge = rem >= ACC_W'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= DS_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_dstate <= n_dstate;
            r_done   <= (r_dstate == DS_FIX);
        end
    end

    always_comb begin
        n_dstate = r_dstate;
        o_mul_a  = '0;
        o_mul_b  = '0;
        unique case (r_dstate)
            DS_IDLE: begin
                if (i_req.start) begin
                    n_dstate = DS_EST;
                end
            end
            DS_EST: begin
                o_mul_a  = DIV_RECIP;
                o_mul_b  = MUL_B_W'(r_num[ACC_W-1:DIV_HI_LSB]);
                n_dstate = DS_BACK;
            end
            DS_BACK: begin
                o_mul_a  = MUL_A_W'(DIVISOR);
                o_mul_b  = r_quo;
                n_dstate = DS_FIX;
            end
            DS_FIX: begin
                n_dstate = DS_IDLE;
            end
            default: begin
                n_dstate = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
        end
        if (r_dstate == DS_EST) begin
            r_quo <= i_mul_p[DIV_RECIP_SHIFT +: DIST_W];
        end
        if (r_dstate == DS_BACK) begin
            r_back <= i_mul_p;
        end
        // estimate is at most one low
        if ((r_dstate == DS_FIX) && rem_ge) begin
            r_quo <= r_quo + DIST_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `IRLE_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, i_req.start, r_dstate == DS_IDLE)
    `IRLE_ASSERT_IMP(a_div_rem_below, i_clk, i_rst_n, r_dstate == DS_FIX, rem < ACC_W'(2 * DIVISOR))
    `IRLE_ASSERT_NEXT(a_div_finish, i_clk, i_rst_n, r_dstate == DS_FIX, r_done && (r_dstate == DS_IDLE))

endmodule

// ----- src/ir_range_linearizer_ema_top.sv -----
// ir range linearizer with moving-average smoothing, top level
//
//   channel    dir   handshake      payload
//   i_cfg      in    valid/ready    smoothing_gain (17b, Q16), ready always high
//   i_sample   in    valid/ready    adc_sample (10b)
//   o_result   out   valid/ready    raw_distance, filtered_distance (20b Q16), range_status
//
// in-range item: scale, segment, slope multiply, subtract, then the divide by 1e8 in irle_div
// (reciprocal estimate, back-multiply, one correction), then mix; a segment clamped to zero skips
// the divide, a too-far / too-near item skips multiply, subtract and divide; a priming item gives no
// result. one multiplier is shared by slope, divide, priming reciprocal and both average terms.
// i_sample.ready is high only while the sequencer is idle; a result held in the output
// register does not block the next item, only the load of the following result.
// synchronous active-low reset: gain back to 0.5, average and priming count cleared.
`include "ir_range_linearizer_ema_top_assert.svh"

module ir_range_linearizer_ema_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irle_cfg_if.sink      i_cfg,
    irle_sample_if.sink   i_sample,
    irle_result_if.source o_result
);
    import irle_pkg::*;

    t_state            r_state;
    t_state            n_state;

    logic [GAIN_W-1:0] r_gain;
    logic [V_W-1:0]    r_v;
    logic [V_W-1:0]    r_y;
    logic [SEG_W-1:0]  r_seg;
    t_range_status     r_status;
    logic [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_avg;
    logic [PRIME_W-1:0] r_prime_cnt;
    logic [MIX_W-1:0]  r_acc;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_raw;
    logic [DIST_W-1:0] r_out_filt;
    t_range_status     r_out_status;

    logic              sample_rdy;
    logic              sample_acc;
    logic              out_load;
    logic              priming;
    logic [GAIN_W-1:0] gain_c;
    logic [V_W-1:0]    scale_q;
    logic              too_far;
    logic              too_near;
    logic [SEG_W-1:0]  seg_k;
    logic [PROD_W-1:0] icpt_ext;
    logic              seg_neg;
    logic [DIST_W-1:0] avg_new;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [MUL_A_W-1:0] div_mul_a;
    logic [MUL_B_W-1:0] div_mul_b;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    irle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_mul_p (mul_p),
        .o_mul_a (div_mul_a),
        .o_mul_b (div_mul_b),
        .o_rsp   (div_rsp)
    );

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = sample_rdy;
    assign sample_acc     = i_sample.valid && sample_rdy;
    assign out_load       = (r_state == S_FIN) && (!r_out_valid || o_result.ready);
    assign priming        = r_prime_cnt < PRIME_W'(PRIME_COUNT);
    assign gain_c         = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign avg_new        = r_acc[GAIN_FRAC +: DIST_W];

    // floor(y / ADC_MAX) for y below 2^(2*ADC_BITS)
    assign scale_q = V_W'(((V_W+1)'(r_y) + (V_W+1)'(r_y >> ADC_BITS) + (V_W+1)'(1))
                          >> ADC_BITS);

    assign too_far  = r_v < THRESH[0];
    assign too_near = r_v >= THRESH[TH_N-1];

    always_comb begin
        seg_k = '0;
        for (int j = 1; j < TH_N - 1; j++) begin
            if (r_v >= THRESH[j]) begin
                seg_k = seg_k + SEG_W'(1);
            end
        end
    end

    assign icpt_ext = PROD_W'(ICPT[r_seg]) << FRAC_BITS;
    assign seg_neg  = r_prod >= icpt_ext;
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        sample_rdy       = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = ACC_W'(icpt_ext - r_prod);
        unique case (r_state)
            S_IDLE: begin
                sample_rdy = 1'b1;
                if (i_sample.valid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_SEG;
            end
            S_SEG: begin
                if (too_far || too_near) begin
                    n_state = S_MIX;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                mul_a   = SLOPE_MAG[r_seg];
                mul_b   = MUL_B_W'(r_v);
                n_state = S_SUB;
            end
            S_SUB: begin
                // segment value at or below zero clamps to zero
                if (seg_neg) begin
                    n_state = S_MIX;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                // divider drives the shared multiplier
                mul_a = div_mul_a;
                mul_b = div_mul_b;
                if (div_rsp.done) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                mul_b = r_dist;
                if (priming) begin
                    mul_a   = MUL_A_W'(PRIME_RECIP);
                    n_state = S_PRIME;
                end else begin
                    mul_a   = MUL_A_W'(gain_c);
                    n_state = S_AVG;
                end
            end
            S_PRIME: begin
                n_state = S_IDLE;
            end
            S_AVG: begin
                mul_a   = MUL_A_W'(GAIN_ONE - gain_c);
                mul_b   = r_avg;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_avg       <= '0;
            r_prime_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_gain <= i_cfg.smoothing_gain;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_PRIME) begin
                r_avg       <= r_avg + r_prod[PRIME_SHIFT +: DIST_W];
                r_prime_cnt <= r_prime_cnt + PRIME_W'(1);
            end else if (out_load) begin
                r_avg <= avg_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_v <= V_W'(32'(i_sample.adc_sample) * SCALE_INT);
            r_y <= V_W'(32'(i_sample.adc_sample) * SCALE_REM);
        end
        if (r_state == S_SCALE) begin
            r_v <= r_v + scale_q;
        end
        if (r_state == S_SEG) begin
            r_seg <= seg_k;
            if (too_far) begin
                r_status <= RS_TOO_FAR;
                r_dist   <= FAR_Q;
            end else if (too_near) begin
                r_status <= RS_TOO_NEAR;
                r_dist   <= '0;
            end else begin
                r_status <= RS_IN_RANGE;
            end
        end
        if ((r_state == S_MUL) || (r_state == S_MIX)) begin
            r_prod <= mul_p;
        end
        if ((r_state == S_SUB) && seg_neg) begin
            r_dist <= '0;
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_dist <= div_rsp.quotient;
        end
        if (r_state == S_AVG) begin
            r_acc <= MIX_W'(r_prod) + MIX_W'(mul_p);
        end
        if (out_load) begin
            r_out_raw    <= r_dist;
            r_out_filt   <= avg_new;
            r_out_status <= r_status;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.raw_distance      = r_out_raw;
    assign o_result.filtered_distance = r_out_filt;
    assign o_result.range_status      = r_out_status;

    `IRLE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, sample_acc, r_state == S_SCALE)
    `IRLE_ASSERT_IMP(a_no_result_priming, i_clk, i_rst_n, r_state == S_FIN, r_prime_cnt == PRIME_W'(PRIME_COUNT))
    `IRLE_ASSERT_IMP(a_near_is_zero, i_clk, i_rst_n, r_out_valid && (r_out_status == RS_TOO_NEAR), r_out_raw == '0)
    `IRLE_ASSERT_ALWAYS(a_prime_bound, i_clk, i_rst_n, r_prime_cnt <= PRIME_W'(PRIME_COUNT))

endmodule
